>>> hw/rtl/cmb_pkg.sv
// shared types and constants of the combined simulation relation block
package cmb_pkg;

	localparam int ROW_W  = 32;
	localparam int IDX_W  = 5;
	localparam int SIZE_W = 6;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_WR_DOWN = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_UP   = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	typedef struct packed {
		logic             wr_down;
		logic             wr_up;
		logic [IDX_W-1:0] row_index;
		logic [ROW_W-1:0] row_bits;
		logic             load;
		logic             shift;
		logic [ROW_W-1:0] di;
		logic [ROW_W-1:0] mask;
	} cmb_ctrl_t;

endpackage

>>> hw/rtl/cmb_if.sv
// valid/ready channels for command items and result items
interface cmb_in_if import cmb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [IDX_W-1:0] row_index;
	logic [ROW_W-1:0] row_bits;

	modport source (output valid, output opcode, output row_index, output row_bits,
		input ready);
	modport sink (input valid, input opcode, input row_index, input row_bits,
		output ready);
endinterface

interface cmb_out_if import cmb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] result_row;
	logic [ROW_W-1:0] result_bits;
	logic             last;

	modport source (output valid, output result_row, output result_bits, output last,
		input ready);
	modport sink (input valid, input result_row, input result_bits, input last,
		output ready);
endinterface

>>> hw/rtl/combined_simulation_relation.sv
// top level: row sequencer, chain of relation cells and result register
// write items are taken whenever the sequencer is idle; cmd.ready is high only while no compute runs
// compute: per row of the effective size n, one column pass (ST_COMP) and one check pass (ST_RES)
//   across the cell chain; a result row that rsp does not take holds the row walk in ST_RES
// reset clears the sequencer, output valid and the size register size_q (to 32);
//   relation rows are undefined until written
module combined_simulation_relation import cmb_pkg::*; #(
	parameter int MAX_STATES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	cmb_in_if.sink            cmd,
	cmb_out_if.source         rsp
);

	localparam int ROW_LIMIT = (MAX_STATES < ROW_W) ? MAX_STATES : ROW_W;
	localparam int CNT_W     = $clog2(ROW_LIMIT);
	localparam logic [SIZE_W-1:0] LIMIT_V = SIZE_W'(ROW_LIMIT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COMP = 2'd1;
	localparam logic [1:0] ST_RES  = 2'd2;

	logic [1:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROW_W-1:0]  comp_s1;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_row_q;
	logic [ROW_W-1:0]  out_bits_q;
	logic              out_last_q;

	logic [SIZE_W-1:0] n_eff;
	logic [ROW_W-1:0]  mask;
	logic              cmd_fire;
	logic              is_last;
	logic              res_fire;
	cmb_ctrl_t         ctrl;
	logic [ROW_W-1:0]  rot_w [ROW_LIMIT+1];
	logic [ROW_LIMIT-1:0] comp_bits;
	logic [ROW_LIMIT-1:0] res_bits;

	always_comb begin
		if (size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (size_q > LIMIT_V) begin
			n_eff = LIMIT_V;
		end else begin
			n_eff = size_q;
		end
		for (int b = 0; b < ROW_W; b++) begin
			mask[b] = (SIZE_W'(b) < n_eff);
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid & cmd.ready;
	assign is_last   = (SIZE_W'(cnt_q) == n_eff - SIZE_W'(1));
	assign res_fire  = (state_q == ST_RES) & (~out_valid_q | rsp.ready);

	always_comb begin
		ctrl.wr_down   = cmd_fire & (cmd.opcode == OP_WR_DOWN);
		ctrl.wr_up     = cmd_fire & (cmd.opcode == OP_WR_UP);
		ctrl.row_index = cmd.row_index;
		ctrl.row_bits  = cmd.row_bits;
		ctrl.load      = cmd_fire & (cmd.opcode == OP_COMPUTE);
		ctrl.shift     = (state_q == ST_COMP);
		ctrl.di        = rot_w[0];
		ctrl.mask      = mask;
	end

	assign rot_w[ROW_LIMIT] = '0;

	for (genvar j = 0; j < ROW_LIMIT; j++) begin : g_cell
		cmb_cell #(
			.IDX(j)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.rot_in   (rot_w[j+1]),
			.comp     (comp_s1),
			.rot_out  (rot_w[j]),
			.comp_bit (comp_bits[j]),
			.res_bit  (res_bits[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(32);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.load) begin
						state_q <= ST_COMP;
						cnt_q   <= '0;
					end
				end
				ST_COMP: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_fire) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_COMP;
							cnt_q   <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			comp_s1 <= ROW_W'(comp_bits);
		end
		if (res_fire) begin
			out_row_q  <= IDX_W'(cnt_q);
			out_bits_q <= ROW_W'(res_bits);
			out_last_q <= is_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_row  = out_row_q;
	assign rsp.result_bits = out_bits_q;
	assign rsp.last        = out_last_q;

	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> state_q == ST_COMP)
		else $error("compute item did not start the row walk");

	a_bits_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.result_bits & ~mask) == '0)
		else $error("result bits set beyond relation size");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last) |-> SIZE_W'(rsp.result_row) == n_eff - SIZE_W'(1))
		else $error("last marker on wrong row");

	a_comp_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES) |-> (comp_s1 & ~mask) == '0)
		else $error("composition bits set beyond relation size");

endmodule

>>> hw/rtl/cmb_cell.sv
// one cell of the chain: holds one downward and one upward row, one column of the result
module cmb_cell import cmb_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cmb_ctrl_t        ctrl,
	input  logic [ROW_W-1:0] rot_in,
	input  logic [ROW_W-1:0] comp,
	output logic [ROW_W-1:0] rot_out,
	output logic             comp_bit,
	output logic             res_bit
);

	localparam logic [IDX_W-1:0] IDX_V = IDX_W'(IDX);

	logic [ROW_W-1:0] down_q;
	logic [ROW_W-1:0] up_q;
	logic [ROW_W-1:0] rot_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_down && ctrl.row_index == IDX_V) begin
			down_q <= ctrl.row_bits;
		end
		if (ctrl.wr_up && ctrl.row_index == IDX_V) begin
			up_q <= ctrl.row_bits;
		end
		if (ctrl.load) begin
			rot_q <= down_q;
		end else if (ctrl.shift) begin
			rot_q <= rot_in;
		end
	end

	assign rot_out  = rot_q;
	// composition column: some k with down(i,k) and up(j,k)
	assign comp_bit = ctrl.mask[IDX] & (|(ctrl.di & ctrl.mask & up_q));
	// keep pair only if down(j) is covered by the composition row
	assign res_bit  = comp[IDX] & ~(|(down_q & ctrl.mask & ~comp));

endmodule
